@@ rtl/aee_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression evaluator package
// Operator, lexer and status codes, the character classes and the item
// that travels from the front end to the execution unit.
// ----------------------------------------------------------------------------
package aee_pkg;

   // Binary operators. OP_NONE marks that no operator is pending.
   localparam logic [4:0] OP_ADD  = 5'd0;
   localparam logic [4:0] OP_SUB  = 5'd1;
   localparam logic [4:0] OP_MUL  = 5'd2;
   localparam logic [4:0] OP_DIV  = 5'd3;
   localparam logic [4:0] OP_MOD  = 5'd4;
   localparam logic [4:0] OP_XOR  = 5'd5;
   localparam logic [4:0] OP_BAND = 5'd6;
   localparam logic [4:0] OP_BOR  = 5'd7;
   localparam logic [4:0] OP_SHL  = 5'd8;
   localparam logic [4:0] OP_SHR  = 5'd9;
   localparam logic [4:0] OP_LAND = 5'd10;
   localparam logic [4:0] OP_LOR  = 5'd11;
   localparam logic [4:0] OP_LT   = 5'd12;
   localparam logic [4:0] OP_GT   = 5'd13;
   localparam logic [4:0] OP_LE   = 5'd14;
   localparam logic [4:0] OP_GE   = 5'd15;
   localparam logic [4:0] OP_EQ   = 5'd16;
   localparam logic [4:0] OP_NE   = 5'd17;
   localparam logic [4:0] OP_NONE = 5'd18;

   // Lexer modes.
   localparam logic [3:0] LX_OPERAND  = 4'd0;
   localparam logic [3:0] LX_DOLLAR   = 4'd1;
   localparam logic [3:0] LX_HEX      = 4'd2;
   localparam logic [3:0] LX_BIN      = 4'd3;
   localparam logic [3:0] LX_NUM      = 4'd4;
   localparam logic [3:0] LX_QOPEN    = 4'd5;
   localparam logic [3:0] LX_QESC     = 4'd6;
   localparam logic [3:0] LX_QCLOSE   = 4'd7;
   localparam logic [3:0] LX_OPWAIT   = 4'd8;
   localparam logic [3:0] LX_OPERATOR = 4'd9;
   localparam logic [3:0] LX_DONE     = 4'd10;
   localparam logic [3:0] LX_ERROR    = 4'd11;

   // Status codes.
   localparam logic [3:0] ST_OK     = 4'd0;
   localparam logic [3:0] ST_VALUE  = 4'd1;
   localparam logic [3:0] ST_OPER   = 4'd2;
   localparam logic [3:0] ST_PREFIX = 4'd3;
   localparam logic [3:0] ST_HEX    = 4'd4;
   localparam logic [3:0] ST_DEC    = 4'd5;
   localparam logic [3:0] ST_BIN    = 4'd6;
   localparam logic [3:0] ST_DEPTH  = 4'd7;
   localparam logic [3:0] ST_DIV0   = 4'd8;
   localparam logic [3:0] ST_NAME   = 4'd9;

   // 'A' - 10, turns an upper-case hex letter into its digit value.
   localparam logic [7:0] HEX_ALPHA_BIAS = 8'd55;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic       digit;
      logic       alpha;
      logic       hex_ok;
      logic [3:0] hex_val;
      logic       space;
      logic       term;
   } char_class_type;

   typedef struct packed {
      logic [7:0]     ch;
      logic           last;
      char_class_type cls;
   } item_type;

   typedef struct packed {
      logic start;
      logic div;
      logic modulo;
   } mdu_cmd_type;

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic char_class_type char_class(input logic [7:0] c);
      char_class_type r;
      logic [7:0]     u;
      u         = to_upper(c);
      r.digit   = (c >= "0") && (c <= "9");
      r.alpha   = (u >= "A") && (u <= "Z");
      r.hex_ok  = r.digit || ((u >= "A") && (u <= "F"));
      r.hex_val = r.digit ? c[3:0] : 4'(u - HEX_ALPHA_BIAS);
      r.space   = (c == " ") || (c == 8'h09);
      r.term    = (c == 8'h00) || (c == 8'h0a) || (c == 8'h0d) || (c == ";") || (c == "\\");
      return r;
   endfunction

endpackage

@@ rtl/aee_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression evaluator front end
// Accepts one character item, classifies it and holds it until the queue
// takes it.
// ----------------------------------------------------------------------------
module aee_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_text_char,
   input  logic              req_is_last,
   output logic              push_valid,
   output aee_pkg::item_type push_item,
   input  logic              push_ready
);
   import aee_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign req_stall  = valid_ff && !push_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_valid && !req_stall) begin
         valid_in     = 1'b1;
         item_in.ch   = req_text_char;
         item_in.last = req_is_last;
         item_in.cls  = char_class(req_text_char);
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

@@ rtl/aee_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression evaluator item queue
// Short first-in first-out buffer between the front end and the execution
// unit.
// ----------------------------------------------------------------------------
module aee_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  aee_pkg::item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output aee_pkg::item_type pop_item,
   input  logic              pop_take
);
   import aee_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_take && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/aee_mdu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression evaluator multiply and divide unit
// Shift-add multiplier and restoring divider, one bit per cycle. Division
// and remainder are signed and truncate toward zero.
// ----------------------------------------------------------------------------
module aee_mdu #(
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  aee_pkg::mdu_cmd_type    cmd,
   input  logic [VALUE_BITS-1:0]   op_a,
   input  logic [VALUE_BITS-1:0]   op_b,
   output logic                    done,
   output logic [VALUE_BITS-1:0]   result
);
   import aee_pkg::*;

   localparam int VB = VALUE_BITS;
   localparam int NW = $clog2(VB + 1);

   logic          busy_ff, busy_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [VB-1:0] acc_ff, acc_in;
   logic [VB-1:0] x_ff, x_in;
   logic [VB-1:0] y_ff, y_in;
   logic [VB-1:0] rem_ff, rem_in;
   logic          neg_ff, neg_in;
   logic          div_ff, div_in;
   logic          mod_ff, mod_in;
   logic [VB:0]   partial;
   logic [VB-1:0] abs_a, abs_b;

   assign abs_a   = op_a[VB-1] ? VB'(0) - op_a : op_a;
   assign abs_b   = op_b[VB-1] ? VB'(0) - op_b : op_b;
   assign partial = {rem_ff, x_ff[VB-1]};
   assign done    = busy_ff && (cnt_ff == NW'(VB));

   always_comb begin
      if (!div_ff) begin
         result = acc_ff;
      end else if (mod_ff) begin
         result = neg_ff ? VB'(0) - rem_ff : rem_ff;
      end else begin
         result = neg_ff ? VB'(0) - x_ff : x_ff;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      div_in  = div_ff;
      mod_in  = mod_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = cmd.div;
         mod_in  = cmd.modulo;
         acc_in  = '0;
         rem_in  = '0;
         if (cmd.div) begin
            x_in   = abs_a;
            y_in   = abs_b;
            neg_in = cmd.modulo ? op_a[VB-1] : (op_a[VB-1] ^ op_b[VB-1]);
         end else begin
            x_in   = op_a;
            y_in   = op_b;
            neg_in = 1'b0;
         end
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (!div_ff) begin
            if (y_ff[0]) begin
               acc_in = acc_ff + x_ff;
            end
            x_in = {x_ff[VB-2:0], 1'b0};
            y_in = {1'b0, y_ff[VB-1:1]};
         end else if (partial >= {1'b0, y_ff}) begin
            rem_in = VB'(partial - {1'b0, y_ff});
            x_in   = {x_ff[VB-2:0], 1'b1};
         end else begin
            rem_in = partial[VB-1:0];
            x_in   = {x_ff[VB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      div_ff <= div_in;
      mod_ff <= mod_in;
   end

endmodule

@@ rtl/aee_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression evaluator execution unit
// Lexer state machine, left-to-right operator evaluation, parenthesis frame
// stack and the result register.
// ----------------------------------------------------------------------------
module aee_back #(
   parameter int VALUE_BITS  = 32,
   parameter int MAX_NESTING = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  aee_pkg::item_type     q_item,
   output logic                  q_take,
   input  logic [VALUE_BITS-1:0] cur_addr,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_result_value,
   output logic [3:0]            rsp_status,
   output logic                  rsp_warn_unclosed,
   output logic                  rsp_warn_extra_paren,
   output logic                  rsp_warn_missing_quote
);
   import aee_pkg::*;

   localparam int VB = VALUE_BITS;
   localparam int AW = (MAX_NESTING > 2) ? $clog2(MAX_NESTING) : 1;
   localparam int FW = VB + 7;
   localparam int SW = $clog2(VB);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_STEP   = 3'd1;
   localparam logic [2:0] S_POPLD  = 3'd2;
   localparam logic [2:0] S_FIN    = 3'd3;
   localparam logic [2:0] S_MDU    = 3'd4;
   localparam logic [2:0] S_FINAL  = 3'd5;
   localparam logic [2:0] S_UNWIND = 3'd6;

   // Where to go once an operand has been folded into the total.
   localparam logic [1:0] CONT_CHAR   = 2'd0;
   localparam logic [1:0] CONT_RETRY  = 2'd1;
   localparam logic [1:0] CONT_UNWIND = 2'd2;

   logic [2:0]     state_ff, state_in;
   logic [1:0]     cont_ff, cont_in;
   logic [3:0]     lx_ff, lx_in;
   logic [7:0]     c_ff, c_in;
   char_class_type cls_ff, cls_in;
   logic           last_ff, last_in;
   logic [7:0]     held_ff, held_in;
   logic [VB-1:0]  rt_ff, rt_in;
   logic [VB-1:0]  opnd_ff, opnd_in;
   logic [4:0]     pop_ff, pop_in;
   logic           inv_ff, inv_in;
   logic           neg_ff, neg_in;
   logic [AW-1:0]  nest_ff, nest_in;
   logic [VB-1:0]  hacc_ff, hacc_in;
   logic [VB-1:0]  dacc_ff, dacc_in;
   logic [VB-1:0]  bacc_ff, bacc_in;
   logic           hbad_ff, hbad_in;
   logic           dbad_ff, dbad_in;
   logic           bbad_ff, bbad_in;
   logic [3:0]     err_ff, err_in;
   logic           wu_ff, wu_in;
   logic           wx_ff, wx_in;
   logic           wq_ff, wq_in;

   logic           ov_ff;
   logic [31:0]    oval_ff;
   logic [3:0]     ost_ff;
   logic           owu_ff, owx_ff, owq_ff;
   logic           out_load;

   logic [FW-1:0]  frame_mem [MAX_NESTING];
   logic [FW-1:0]  rd_ff;
   logic           push_we;

   mdu_cmd_type    mdu_cmd;
   logic           mdu_done;
   logic [VB-1:0]  mdu_result;

   char_class_type hc;
   logic           unary, fail_now, go_fin, held_bin, c_bin;
   logic [3:0]     fail_code;
   logic [7:0]     held_up, c_up;
   logic [VB-1:0]  hex_c, dec_c, bin_c, hex_h, dec_h, bin_h;
   logic           res_bad;
   logic [VB-1:0]  res_val;
   logic [3:0]     res_err;
   logic [4:0]     op2;
   logic [VB-1:0]  fv, alu_res;
   logic [1:0]     next_cont;

   aee_mdu #(.VALUE_BITS(VB)) u_mdu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mdu_cmd),
      .op_a   (rt_ff),
      .op_b   (fv),
      .done   (mdu_done),
      .result (mdu_result)
   );

   assign hc       = char_class(held_ff);
   assign held_up  = to_upper(held_ff);
   assign c_up     = to_upper(c_ff);
   assign unary    = inv_ff || neg_ff;
   assign held_bin = (held_ff == "0") || (held_ff == "1");
   assign c_bin    = (c_ff == "0") || (c_ff == "1");

   assign hex_c = {hacc_ff[VB-5:0], cls_ff.hex_val};
   assign dec_c = (dacc_ff << 3) + (dacc_ff << 1) + VB'(c_ff[3:0]);
   assign bin_c = {bacc_ff[VB-2:0], c_ff[0]};
   assign hex_h = {hacc_ff[VB-5:0], hc.hex_val};
   assign dec_h = (dacc_ff << 3) + (dacc_ff << 1) + VB'(held_ff[3:0]);
   assign bin_h = {bacc_ff[VB-2:0], held_ff[0]};

   // Radix resolution of a finished literal. In a plain number the last
   // character picks the radix, or is itself a decimal digit.
   always_comb begin
      case (lx_ff)
         LX_HEX: begin
            res_bad = hbad_ff; res_val = hacc_ff; res_err = ST_HEX;
         end
         LX_BIN: begin
            res_bad = bbad_ff; res_val = bacc_ff; res_err = ST_BIN;
         end
         default: begin
            if (held_up == "H") begin
               res_bad = hbad_ff; res_val = hacc_ff; res_err = ST_HEX;
            end else if (held_up == "B") begin
               res_bad = bbad_ff; res_val = bacc_ff; res_err = ST_BIN;
            end else if (held_up == "D") begin
               res_bad = dbad_ff; res_val = dacc_ff; res_err = ST_DEC;
            end else begin
               res_bad = dbad_ff || !hc.digit; res_val = dec_h; res_err = ST_DEC;
            end
         end
      endcase
   end

   always_comb begin
      op2 = OP_NONE;
      if (held_ff == "<" && c_ff == "<") op2 = OP_SHL;
      else if (held_ff == "<" && c_ff == "=") op2 = OP_LE;
      else if (held_ff == ">" && c_ff == ">") op2 = OP_SHR;
      else if (held_ff == ">" && c_ff == "=") op2 = OP_GE;
      else if (held_ff == "&" && c_ff == "&") op2 = OP_LAND;
      else if (held_ff == "|" && c_ff == "|") op2 = OP_LOR;
      else if (held_ff == "=" && c_ff == "=") op2 = OP_EQ;
      else if (held_ff == "!" && c_ff == "=") op2 = OP_NE;
   end

   // Operand after its unary prefix, and the operators that need no multiply/divide unit.
   always_comb begin
      fv = opnd_ff;
      if (inv_ff) fv = ~fv;
      if (neg_ff) fv = VB'(0) - fv;
   end

   always_comb begin
      case (pop_ff)
         OP_ADD:  alu_res = rt_ff + fv;
         OP_SUB:  alu_res = rt_ff - fv;
         OP_XOR:  alu_res = rt_ff ^ fv;
         OP_BAND: alu_res = rt_ff & fv;
         OP_BOR:  alu_res = rt_ff | fv;
         OP_SHL: begin
            if (fv[VB-1] || fv >= VB'(VB)) alu_res = '0;
            else alu_res = rt_ff << fv[SW-1:0];
         end
         OP_SHR: begin
            if (fv[VB-1] || fv >= VB'(VB)) alu_res = {VB{rt_ff[VB-1]}};
            else alu_res = VB'($signed(rt_ff) >>> fv[SW-1:0]);
         end
         OP_LAND: alu_res = VB'((rt_ff != '0) && (fv != '0));
         OP_LOR:  alu_res = VB'((rt_ff != '0) || (fv != '0));
         OP_LT:   alu_res = VB'($signed(rt_ff) < $signed(fv));
         OP_GT:   alu_res = VB'($signed(rt_ff) > $signed(fv));
         OP_LE:   alu_res = VB'($signed(rt_ff) <= $signed(fv));
         OP_GE:   alu_res = VB'($signed(rt_ff) >= $signed(fv));
         OP_EQ:   alu_res = VB'(rt_ff == fv);
         OP_NE:   alu_res = VB'(rt_ff != fv);
         default: alu_res = fv;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      cont_in   = cont_ff;
      lx_in     = lx_ff;
      c_in      = c_ff;
      cls_in    = cls_ff;
      last_in   = last_ff;
      held_in   = held_ff;
      rt_in     = rt_ff;
      opnd_in   = opnd_ff;
      pop_in    = pop_ff;
      inv_in    = inv_ff;
      neg_in    = neg_ff;
      nest_in   = nest_ff;
      hacc_in   = hacc_ff;
      dacc_in   = dacc_ff;
      bacc_in   = bacc_ff;
      hbad_in   = hbad_ff;
      dbad_in   = dbad_ff;
      bbad_in   = bbad_ff;
      err_in    = err_ff;
      wu_in     = wu_ff;
      wx_in     = wx_ff;
      wq_in     = wq_ff;
      q_take    = 1'b0;
      push_we   = 1'b0;
      mdu_cmd   = '0;
      out_load  = 1'b0;
      fail_now  = 1'b0;
      fail_code = ST_OK;
      go_fin    = 1'b0;
      next_cont = cont_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_take   = 1'b1;
               c_in     = q_item.ch;
               last_in  = q_item.last;
               cls_in   = q_item.cls;
               state_in = S_STEP;
            end
         end

         S_STEP: begin
            // One pass of the lexer over the current character. A pass that
            // does not use the character up comes back here, after any operand
            // that it ended has been folded in.
            state_in = last_ff ? S_FINAL : S_IDLE;
            case (lx_ff)
               LX_OPERAND: begin
                  if (!unary && cls_ff.space) begin
                     state_in = state_in;
                  end else if (c_ff == 8'h00) begin
                     fail_now  = 1'b1;
                     fail_code = unary ? ST_PREFIX : ST_VALUE;
                  end else if (!unary && c_ff == "~") begin
                     inv_in = 1'b1;
                  end else if (!unary && c_ff == "-") begin
                     neg_in = 1'b1;
                  end else if (c_ff == "(") begin
                     if ({1'b0, nest_ff} + 1'b1 >= (AW + 1)'(MAX_NESTING)) begin
                        fail_now  = 1'b1;
                        fail_code = ST_DEPTH;
                     end else begin
                        push_we = 1'b1;
                        nest_in = nest_ff + 1'b1;
                        rt_in   = '0;
                        pop_in  = OP_NONE;
                        inv_in  = 1'b0;
                        neg_in  = 1'b0;
                     end
                  end else begin
                     hacc_in = '0;
                     dacc_in = '0;
                     bacc_in = '0;
                     hbad_in = 1'b0;
                     dbad_in = 1'b0;
                     bbad_in = 1'b0;
                     if (c_ff == "$") begin
                        lx_in = LX_DOLLAR;
                     end else if (c_ff == "%") begin
                        lx_in = LX_BIN;
                     end else if (c_ff == "'") begin
                        lx_in = LX_QOPEN;
                     end else if (cls_ff.digit) begin
                        held_in = c_ff;
                        lx_in   = LX_NUM;
                     end else if (cls_ff.alpha || c_ff == "_") begin
                        fail_now  = 1'b1;
                        fail_code = ST_NAME;
                     end else begin
                        fail_now  = 1'b1;
                        fail_code = ST_PREFIX;
                     end
                  end
               end

               LX_DOLLAR: begin
                  if (cls_ff.hex_ok) begin
                     hacc_in = hex_c;
                     if (cls_ff.digit) dacc_in = dec_c; else dbad_in = 1'b1;
                     if (c_bin) bacc_in = bin_c; else bbad_in = 1'b1;
                     lx_in = LX_HEX;
                  end else begin
                     opnd_in   = cur_addr;
                     go_fin    = 1'b1;
                     next_cont = CONT_RETRY;
                  end
               end

               LX_HEX, LX_BIN: begin
                  if (cls_ff.digit || cls_ff.alpha) begin
                     if (cls_ff.hex_ok) hacc_in = hex_c; else hbad_in = 1'b1;
                     if (cls_ff.digit) dacc_in = dec_c; else dbad_in = 1'b1;
                     if (c_bin) bacc_in = bin_c; else bbad_in = 1'b1;
                  end else if (res_bad) begin
                     fail_now  = 1'b1;
                     fail_code = res_err;
                  end else begin
                     opnd_in   = res_val;
                     go_fin    = 1'b1;
                     next_cont = CONT_RETRY;
                  end
               end

               LX_NUM: begin
                  if (cls_ff.digit || cls_ff.alpha) begin
                     if (hc.hex_ok) hacc_in = hex_h; else hbad_in = 1'b1;
                     if (hc.digit) dacc_in = dec_h; else dbad_in = 1'b1;
                     if (held_bin) bacc_in = bin_h; else bbad_in = 1'b1;
                     held_in = c_ff;
                  end else if (res_bad) begin
                     fail_now  = 1'b1;
                     fail_code = res_err;
                  end else begin
                     opnd_in   = res_val;
                     go_fin    = 1'b1;
                     next_cont = CONT_RETRY;
                  end
               end

               LX_QOPEN: begin
                  if (c_ff == "\\") begin
                     lx_in = LX_QESC;
                  end else begin
                     held_in = c_ff;
                     lx_in   = LX_QCLOSE;
                  end
               end

               LX_QESC: begin
                  if (c_up == "N") held_in = 8'h0a;
                  else if (c_up == "R") held_in = 8'h0d;
                  else if (c_up == "T") held_in = 8'h09;
                  else if (c_up == "0") held_in = 8'h00;
                  else held_in = c_ff;
                  lx_in = LX_QCLOSE;
               end

               LX_QCLOSE: begin
                  opnd_in = VB'(held_ff);
                  go_fin  = 1'b1;
                  if (c_ff == "'") begin
                     next_cont = CONT_CHAR;
                  end else begin
                     wq_in     = 1'b1;
                     next_cont = CONT_RETRY;
                  end
               end

               LX_OPWAIT: begin
                  if (op2 != OP_NONE) begin
                     pop_in = op2;
                     lx_in  = LX_OPERAND;
                  end else if (held_ff == "!") begin
                     fail_now  = 1'b1;
                     fail_code = ST_OPER;
                  end else begin
                     // A single-character comparison or bitwise operator;
                     // the current character starts the operand.
                     if (held_ff == "<") pop_in = OP_LT;
                     else if (held_ff == ">") pop_in = OP_GT;
                     else if (held_ff == "&") pop_in = OP_BAND;
                     else if (held_ff == "|") pop_in = OP_BOR;
                     else pop_in = OP_EQ;
                     lx_in    = LX_OPERAND;
                     state_in = S_STEP;
                  end
               end

               LX_OPERATOR: begin
                  if (cls_ff.space) begin
                     state_in = state_in;
                  end else if (cls_ff.term) begin
                     lx_in = LX_DONE;
                  end else if (c_ff == "<" || c_ff == ">" || c_ff == "&" ||
                               c_ff == "|" || c_ff == "=" || c_ff == "!") begin
                     held_in = c_ff;
                     lx_in   = LX_OPWAIT;
                  end else if (c_ff == ")") begin
                     if (nest_ff != '0) begin
                        opnd_in  = rt_ff;
                        nest_in  = nest_ff - 1'b1;
                        cont_in  = CONT_CHAR;
                        state_in = S_POPLD;
                     end else begin
                        wx_in = 1'b1;
                     end
                  end else begin
                     lx_in = LX_OPERAND;
                     if (c_ff == "+") pop_in = OP_ADD;
                     else if (c_ff == "-") pop_in = OP_SUB;
                     else if (c_ff == "*") pop_in = OP_MUL;
                     else if (c_ff == "/") pop_in = OP_DIV;
                     else if (c_ff == "%") pop_in = OP_MOD;
                     else if (c_ff == "^") pop_in = OP_XOR;
                     else begin
                        lx_in     = lx_ff;
                        fail_now  = 1'b1;
                        fail_code = ST_OPER;
                     end
                  end
               end

               default: begin
                  state_in = state_in;
               end
            endcase
            if (go_fin) begin
               cont_in  = next_cont;
               state_in = S_FIN;
            end
         end

         S_POPLD: begin
            rt_in    = rd_ff[FW-1:7];
            pop_in   = rd_ff[6:2];
            inv_in   = rd_ff[1];
            neg_in   = rd_ff[0];
            state_in = S_FIN;
         end

         S_FIN: begin
            inv_in = 1'b0;
            neg_in = 1'b0;
            lx_in  = LX_OPERATOR;
            pop_in = OP_NONE;
            if (pop_ff == OP_MUL || pop_ff == OP_DIV || pop_ff == OP_MOD) begin
               if (pop_ff != OP_MUL && fv == '0) begin
                  fail_now  = 1'b1;
                  fail_code = ST_DIV0;
               end else begin
                  mdu_cmd.start  = 1'b1;
                  mdu_cmd.div    = (pop_ff != OP_MUL);
                  mdu_cmd.modulo = (pop_ff == OP_MOD);
               end
            end else begin
               rt_in = alu_res;
            end
            if (mdu_cmd.start) begin
               state_in = S_MDU;
            end else begin
               case (cont_ff)
                  CONT_RETRY:  state_in = S_STEP;
                  CONT_UNWIND: state_in = S_UNWIND;
                  default:     state_in = last_ff ? S_FINAL : S_IDLE;
               endcase
            end
         end

         S_MDU: begin
            if (mdu_done) begin
               rt_in = mdu_result;
               case (cont_ff)
                  CONT_RETRY:  state_in = S_STEP;
                  CONT_UNWIND: state_in = S_UNWIND;
                  default:     state_in = last_ff ? S_FINAL : S_IDLE;
               endcase
            end
         end

         S_FINAL: begin
            // Close off whatever operand the text ended in.
            state_in = S_UNWIND;
            case (lx_ff)
               LX_OPERAND: begin
                  fail_now  = 1'b1;
                  fail_code = unary ? ST_PREFIX : ST_VALUE;
               end
               LX_DOLLAR: begin
                  opnd_in = cur_addr;
                  go_fin  = 1'b1;
               end
               LX_HEX, LX_BIN, LX_NUM: begin
                  if (res_bad) begin
                     fail_now  = 1'b1;
                     fail_code = res_err;
                  end else begin
                     opnd_in = res_val;
                     go_fin  = 1'b1;
                  end
               end
               LX_QOPEN, LX_QESC: begin
                  wq_in   = 1'b1;
                  opnd_in = '0;
                  go_fin  = 1'b1;
               end
               LX_QCLOSE: begin
                  wq_in   = 1'b1;
                  opnd_in = VB'(held_ff);
                  go_fin  = 1'b1;
               end
               LX_OPWAIT: begin
                  fail_now  = 1'b1;
                  fail_code = (held_ff == "!") ? ST_OPER : ST_VALUE;
               end
               default: begin
                  state_in = S_UNWIND;
               end
            endcase
            if (go_fin) begin
               cont_in  = CONT_UNWIND;
               state_in = S_FIN;
            end
         end

         S_UNWIND: begin
            // Open parentheses are closed innermost first, one per pass.
            if (err_ff == ST_OK && nest_ff != '0) begin
               wu_in    = 1'b1;
               opnd_in  = rt_ff;
               nest_in  = nest_ff - 1'b1;
               cont_in  = CONT_UNWIND;
               state_in = S_POPLD;
            end else if (!ov_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = S_IDLE;
               lx_in    = LX_OPERAND;
               rt_in    = '0;
               pop_in   = OP_NONE;
               inv_in   = 1'b0;
               neg_in   = 1'b0;
               nest_in  = '0;
               hacc_in  = '0;
               dacc_in  = '0;
               bacc_in  = '0;
               hbad_in  = 1'b0;
               dbad_in  = 1'b0;
               bbad_in  = 1'b0;
               held_in  = '0;
               err_in   = ST_OK;
               wu_in    = 1'b0;
               wx_in    = 1'b0;
               wq_in    = 1'b0;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fail_now) begin
         if (err_ff == ST_OK) err_in = fail_code;
         lx_in = LX_ERROR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cont_ff  <= CONT_CHAR;
         lx_ff    <= LX_OPERAND;
         rt_ff    <= '0;
         pop_ff   <= OP_NONE;
         inv_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         nest_ff  <= '0;
         hacc_ff  <= '0;
         dacc_ff  <= '0;
         bacc_ff  <= '0;
         hbad_ff  <= 1'b0;
         dbad_ff  <= 1'b0;
         bbad_ff  <= 1'b0;
         held_ff  <= '0;
         err_ff   <= ST_OK;
         wu_ff    <= 1'b0;
         wx_ff    <= 1'b0;
         wq_ff    <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cont_ff  <= cont_in;
         lx_ff    <= lx_in;
         rt_ff    <= rt_in;
         pop_ff   <= pop_in;
         inv_ff   <= inv_in;
         neg_ff   <= neg_in;
         nest_ff  <= nest_in;
         hacc_ff  <= hacc_in;
         dacc_ff  <= dacc_in;
         bacc_ff  <= bacc_in;
         hbad_ff  <= hbad_in;
         dbad_ff  <= dbad_in;
         bbad_ff  <= bbad_in;
         held_ff  <= held_in;
         err_ff   <= err_in;
         wu_ff    <= wu_in;
         wx_ff    <= wx_in;
         wq_ff    <= wq_in;
         if (out_load) begin
            ov_ff <= 1'b1;
         end else if (!rsp_stall) begin
            ov_ff <= 1'b0;
         end
      end
      c_ff    <= c_in;
      cls_ff  <= cls_in;
      last_ff <= last_in;
      opnd_ff <= opnd_in;
      if (out_load) begin
         oval_ff <= (err_ff == ST_OK) ? 32'($signed(rt_ff)) : '0;
         ost_ff  <= err_ff;
         owu_ff  <= wu_ff;
         owx_ff  <= wx_ff;
         owq_ff  <= wq_ff;
      end
   end

   // Frame stack: one write port for '(' and a registered read of the top.
   always_ff @(posedge clock) begin
      if (push_we) begin
         frame_mem[nest_ff] <= {rt_ff, pop_ff, inv_ff, neg_ff};
      end
      rd_ff <= frame_mem[nest_ff - 1'b1];
   end

   assign rsp_valid              = ov_ff;
   assign rsp_result_value       = oval_ff;
   assign rsp_status             = ost_ff;
   assign rsp_warn_unclosed      = owu_ff;
   assign rsp_warn_extra_paren   = owx_ff;
   assign rsp_warn_missing_quote = owq_ff;

endmodule

@@ rtl/assembler_expression_evaluator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Assembler constant-expression evaluator
// Reads an expression one character per item and returns its value and a
// status after the item marked last.
// ----------------------------------------------------------------------------
// Each character item is classified in the front end and waits in a two-entry
// queue for the execution unit. The character after a one-character comparison
// or bitwise operator is read again, and so is a character that ends an
// operand, once that operand has been folded in; a closing quote also folds
// its operand in. A * / % operand also passes through the bit-serial
// multiply/divide unit, and a ')' that ends such an operand and closes a
// parenthesis that a * / % also waits on uses the unit twice. After the last
// item, each parenthesis still open is closed, and each * / % that closing them
// applies uses the unit again; then the result is loaded. Operators are
// evaluated strictly left to right; at most MAX_NESTING - 1 parentheses may be
// open. The result waits in an output register, so the next expression can be
// accepted while it is still stalled.
module assembler_expression_evaluator_top #(
   parameter int VALUE_BITS  = 32,
   parameter int MAX_NESTING = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_text_char,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic [3:0]         rsp_status,
   output logic               rsp_warn_unclosed,
   output logic               rsp_warn_extra_paren,
   output logic               rsp_warn_missing_quote
);
   import aee_pkg::*;

   logic [VALUE_BITS-1:0] cur_addr_ff;
   logic                  push_valid, push_ready, q_valid, q_take;
   item_type              push_item, q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_addr_ff <= '0;
      end else if (csr_wr_en) begin
         cur_addr_ff <= VALUE_BITS'(csr_wr_data);
      end
   end

   aee_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_char (req_text_char),
      .req_is_last   (req_is_last),
      .push_valid    (push_valid),
      .push_item     (push_item),
      .push_ready    (push_ready)
   );

   aee_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop_take   (q_take)
   );

   aee_back #(
      .VALUE_BITS  (VALUE_BITS),
      .MAX_NESTING (MAX_NESTING)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_valid                (q_valid),
      .q_item                 (q_item),
      .q_take                 (q_take),
      .cur_addr               (cur_addr_ff),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_result_value       (rsp_result_value),
      .rsp_status             (rsp_status),
      .rsp_warn_unclosed      (rsp_warn_unclosed),
      .rsp_warn_extra_paren   (rsp_warn_extra_paren),
      .rsp_warn_missing_quote (rsp_warn_missing_quote)
   );

endmodule

@@ rtl/aee_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression evaluator port checker
// Watches the top-level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
module aee_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_result_value,
   input logic [3:0]         rsp_status
);
   import aee_pkg::*;

   // A failed expression never reports a value.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_result_value == 32'sd0)
      else $error("result value is not zero on an error status");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block is not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value) &&
      $stable(rsp_status))
      else $error("stalled result item changed");

endmodule

bind assembler_expression_evaluator_top aee_checker u_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression evaluator testbench
// Feeds expression text one character per item, with directed cases first
// and then random well-formed, broken and noise expressions. A scoreboard
// predicts value, status and warnings for every expression and checks each
// result, while both handshakes stall at random and the address register
// moves through several settings.
// ----------------------------------------------------------------------------
module tb_top;
   import aee_pkg::*;

   localparam int NEST_LIMIT   = 20;
   localparam int SETTLE       = 1000;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_CHARS = 1450;
   localparam int QUIET_CHARS  = 200;
   localparam int LONG_HOLD    = 400;

   typedef byte unsigned text_type[$];

   typedef struct {
      logic [31:0] value;
      logic [3:0]  status;
      bit          unclosed;
      bit          extra;
      bit          quote;
   } eval_result_type;

   class eval_scoreboard;
      eval_result_type results_due[$];
      int           errors;
      int           checked;
      int           bad_status;
      logic [31:0]  cur_addr;
      logic [31:0]  fr_total[NEST_LIMIT];
      logic [4:0]   fr_op[NEST_LIMIT];
      bit           fr_inv[NEST_LIMIT];
      bit           fr_neg[NEST_LIMIT];
      int           depth;
      logic [31:0]  total;
      logic [4:0]   pend;
      logic [3:0]   mode;
      logic [31:0]  acc[3];
      bit           bad[3];
      byte unsigned held;
      logic [3:0]   err;
      bit           uinv, uneg, w_unc, w_ext, w_q;

      function new();
         cur_addr = '0;
         clear_parse();
      endfunction

      function void clear_parse();
         depth = 0;
         total = '0;
         pend  = OP_NONE;
         mode  = LX_OPERAND;
         clear_accs();
         held  = 0;
         err   = ST_OK;
         uinv  = 0; uneg = 0;
         w_unc = 0; w_ext = 0; w_q = 0;
      endfunction

      function void clear_accs();
         for (int i = 0; i < 3; i++) begin
            acc[i] = '0;
            bad[i] = 0;
         end
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      function void fail(logic [3:0] code);
         if (err == ST_OK) err = code;
         mode = LX_ERROR;
      endfunction

      function bit is_dig(byte unsigned c);
         return c >= "0" && c <= "9";
      endfunction

      function byte unsigned upc(byte unsigned c);
         if (c >= "a" && c <= "z") return c - 8'd32;
         return c;
      endfunction

      function bit is_let(byte unsigned c);
         return upc(c) >= "A" && upc(c) <= "Z";
      endfunction

      function int hexdig(byte unsigned c);
         if (is_dig(c)) return c - "0";
         if (upc(c) >= "A" && upc(c) <= "F") return upc(c) - HEX_ALPHA_BIAS;
         return -1;
      endfunction

      function logic [31:0] apply(logic [4:0] op, logic [31:0] a, logic [31:0] b);
         logic [31:0] sr;
         case (op)
            OP_ADD:  return a + b;
            OP_SUB:  return a - b;
            OP_MUL:  return a * b;
            OP_DIV, OP_MOD: begin
               if (b == 0) begin
                  fail(ST_DIV0);
                  return a;
               end
               // Dividing by -1 is done by hand so the most negative value wraps.
               if (b == '1) return (op == OP_DIV) ? -a : '0;
               if (op == OP_DIV) return $signed(a) / $signed(b);
               return $signed(a) % $signed(b);
            end
            OP_XOR:  return a ^ b;
            OP_BAND: return a & b;
            OP_BOR:  return a | b;
            OP_SHL:  return (b[31] || b >= 32) ? '0 : a << b[4:0];
            OP_SHR: begin
               if (b[31] || b >= 32) return {32{a[31]}};
               sr = $signed(a) >>> b[4:0];
               return sr;
            end
            OP_LAND: return (a != 0 && b != 0) ? 1 : 0;
            OP_LOR:  return (a != 0 || b != 0) ? 1 : 0;
            OP_LT:   return ($signed(a) < $signed(b)) ? 1 : 0;
            OP_GT:   return ($signed(a) > $signed(b)) ? 1 : 0;
            OP_LE:   return ($signed(a) <= $signed(b)) ? 1 : 0;
            OP_GE:   return ($signed(a) >= $signed(b)) ? 1 : 0;
            OP_EQ:   return (a == b) ? 1 : 0;
            OP_NE:   return (a != b) ? 1 : 0;
            default: return b;
         endcase
      endfunction

      function void take_operand(logic [31:0] v);
         if (uinv) v = ~v;
         if (uneg) v = -v;
         uinv = 0; uneg = 0;
         mode = LX_OPERATOR;
         total = (pend == OP_NONE) ? v : apply(pend, total, v);
         pend = OP_NONE;
      endfunction

      function void shift_digit(byte unsigned c);
         int h;
         h = hexdig(c);
         if (h < 0) bad[0] = 1;
         else acc[0] = {acc[0][27:0], 4'(h)};
         if (!is_dig(c)) bad[1] = 1;
         else acc[1] = acc[1] * 10 + 32'(c - "0");
         if (c != "0" && c != "1") bad[2] = 1;
         else acc[2] = {acc[2][30:0], c[0]};
      endfunction

      function void resolve(int r);
         if (bad[r]) fail(r == 0 ? ST_HEX : (r == 1 ? ST_DEC : ST_BIN));
         else take_operand(acc[r]);
      endfunction

      // The last alphanumeric character of a digit run picks the radix.
      function void resolve_suffixed();
         case (upc(held))
            "H": resolve(0);
            "B": resolve(2);
            "D": resolve(1);
            default: begin
               shift_digit(held);
               resolve(1);
            end
         endcase
      endfunction

      function void close_paren();
         logic [31:0] v;
         v = total;
         depth--;
         total = fr_total[depth];
         pend  = fr_op[depth];
         uinv  = fr_inv[depth];
         uneg  = fr_neg[depth];
         take_operand(v);
      endfunction

      function logic [4:0] pair_op(byte unsigned a, byte unsigned b);
         if (a == "<" && b == "<") return OP_SHL;
         if (a == "<" && b == "=") return OP_LE;
         if (a == ">" && b == ">") return OP_SHR;
         if (a == ">" && b == "=") return OP_GE;
         if (a == "&" && b == "&") return OP_LAND;
         if (a == "|" && b == "|") return OP_LOR;
         if (a == "=" && b == "=") return OP_EQ;
         if (a == "!" && b == "=") return OP_NE;
         return OP_NONE;
      endfunction

      // Returns 1 when the character is used up, 0 when it must be read again.
      function bit eat(byte unsigned c);
         bit          un;
         logic [4:0]  op;
         un = uinv || uneg;
         case (mode)
            LX_OPERAND: begin
               if (!un && (c == " " || c == 8'h09)) return 1;
               if (c == 0) begin
                  fail(un ? ST_PREFIX : ST_VALUE);
                  return 1;
               end
               if (!un && c == "~") begin
                  uinv = 1;
                  return 1;
               end
               if (!un && c == "-") begin
                  uneg = 1;
                  return 1;
               end
               if (c == "(") begin
                  if (depth + 1 >= NEST_LIMIT) begin
                     fail(ST_DEPTH);
                     return 1;
                  end
                  fr_total[depth] = total;
                  fr_op[depth]    = pend;
                  fr_inv[depth]   = uinv;
                  fr_neg[depth]   = uneg;
                  depth++;
                  total = '0;
                  pend  = OP_NONE;
                  uinv  = 0; uneg = 0;
                  return 1;
               end
               clear_accs();
               if (c == "$") mode = LX_DOLLAR;
               else if (c == "%") mode = LX_BIN;
               else if (c == "'") mode = LX_QOPEN;
               else if (is_dig(c)) begin
                  held = c;
                  mode = LX_NUM;
               end else if (is_let(c) || c == "_") fail(ST_NAME);
               else fail(ST_PREFIX);
               return 1;
            end
            LX_DOLLAR: begin
               if (hexdig(c) >= 0) begin
                  shift_digit(c);
                  mode = LX_HEX;
                  return 1;
               end
               take_operand(cur_addr);
               return 0;
            end
            LX_HEX, LX_BIN: begin
               if (is_dig(c) || is_let(c)) begin
                  shift_digit(c);
                  return 1;
               end
               resolve(mode == LX_HEX ? 0 : 2);
               return 0;
            end
            LX_NUM: begin
               if (is_dig(c) || is_let(c)) begin
                  shift_digit(held);
                  held = c;
                  return 1;
               end
               resolve_suffixed();
               return 0;
            end
            LX_QOPEN: begin
               if (c == "\\") mode = LX_QESC;
               else begin
                  held = c;
                  mode = LX_QCLOSE;
               end
               return 1;
            end
            LX_QESC: begin
               case (upc(c))
                  "N": held = 8'd10;
                  "R": held = 8'd13;
                  "T": held = 8'd9;
                  "0": held = 8'd0;
                  default: held = c;
               endcase
               mode = LX_QCLOSE;
               return 1;
            end
            LX_QCLOSE: begin
               if (c == "'") begin
                  take_operand(32'(held));
                  return 1;
               end
               w_q = 1;
               take_operand(32'(held));
               return 0;
            end
            LX_OPWAIT: begin
               op = pair_op(held, c);
               if (op != OP_NONE) begin
                  pend = op;
                  mode = LX_OPERAND;
                  return 1;
               end
               case (held)
                  "<": op = OP_LT;
                  ">": op = OP_GT;
                  "&": op = OP_BAND;
                  "|": op = OP_BOR;
                  "=": op = OP_EQ;
                  default: begin
                     fail(ST_OPER);
                     return 1;
                  end
               endcase
               pend = op;
               mode = LX_OPERAND;
               return 0;
            end
            LX_OPERATOR: begin
               if (c == " " || c == 8'h09) return 1;
               if (c == 0 || c == 8'h0a || c == 8'h0d || c == ";" || c == "\\") begin
                  mode = LX_DONE;
                  return 1;
               end
               case (c)
                  "+": op = OP_ADD;
                  "-": op = OP_SUB;
                  "*": op = OP_MUL;
                  "/": op = OP_DIV;
                  "%": op = OP_MOD;
                  "^": op = OP_XOR;
                  "<", ">", "&", "|", "=", "!": begin
                     held = c;
                     mode = LX_OPWAIT;
                     return 1;
                  end
                  ")": begin
                     if (depth > 0) close_paren();
                     else w_ext = 1;
                     return 1;
                  end
                  default: begin
                     fail(ST_OPER);
                     return 1;
                  end
               endcase
               pend = op;
               mode = LX_OPERAND;
               return 1;
            end
            default: return 1;
         endcase
      endfunction

      function void end_of_text();
         case (mode)
            LX_OPERAND: fail((uinv || uneg) ? ST_PREFIX : ST_VALUE);
            LX_DOLLAR:  take_operand(cur_addr);
            LX_HEX:     resolve(0);
            LX_BIN:     resolve(2);
            LX_NUM:     resolve_suffixed();
            LX_QOPEN, LX_QESC: begin
               w_q = 1;
               take_operand('0);
            end
            LX_QCLOSE: begin
               w_q = 1;
               take_operand(32'(held));
            end
            LX_OPWAIT: fail(held == "!" ? ST_OPER : ST_VALUE);
            default: ;
         endcase
         while (err == ST_OK && depth > 0) begin
            w_unc = 1;
            close_paren();
         end
      endfunction

      function void note_char(byte unsigned c, bit last);
         eval_result_type r;
         for (int i = 0; i < 4; i++)
            if (eat(c)) break;
         if (!last) return;
         end_of_text();
         r.value    = (err == ST_OK) ? total : '0;
         r.status   = err;
         r.unclosed = w_unc;
         r.extra    = w_ext;
         r.quote    = w_q;
         results_due.push_back(r);
         clear_parse();
      endfunction

      function void check_result(logic [31:0] value, logic [3:0] status, bit unc, bit ext,
                                 bit q);
         eval_result_type e;
         if (results_due.size() == 0) begin
            $error("result with no expression pending: value %h status %0d", value, status);
            errors++;
            return;
         end
         e = results_due.pop_front();
         checked++;
         if (e.status != ST_OK) bad_status++;
         if (value !== e.value) begin
            $error("result_value: expected %h, actual %h", e.value, value);
            errors++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            errors++;
         end
         if (unc !== e.unclosed) begin
            $error("warn_unclosed: expected %0d, actual %0d", e.unclosed, unc);
            errors++;
         end
         if (ext !== e.extra) begin
            $error("warn_extra_paren: expected %0d, actual %0d", e.extra, ext);
            errors++;
         end
         if (q !== e.quote) begin
            $error("warn_missing_quote: expected %0d, actual %0d", e.quote, q);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_text_char;
   logic        req_is_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic signed [31:0] rsp_result_value;
   logic [3:0]  rsp_status;
   logic        rsp_warn_unclosed;
   logic        rsp_warn_extra_paren;
   logic        rsp_warn_missing_quote;

   eval_scoreboard sb;
   bit  quiet;
   bit  long_hold_req;
   int  cycles;
   int  chars_sent;
   int  exprs_sent;

   assembler_expression_evaluator_top i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_text_char          (req_text_char),
      .req_is_last            (req_is_last),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_result_value       (rsp_result_value),
      .rsp_status             (rsp_status),
      .rsp_warn_unclosed      (rsp_warn_unclosed),
      .rsp_warn_extra_paren   (rsp_warn_extra_paren),
      .rsp_warn_missing_quote (rsp_warn_missing_quote)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("tb_top failed");
         $finish;
      end
   end

   // Both sides are sampled at the edge, before any register moves.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_char(req_text_char, req_is_last);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_result_value, rsp_status, rsp_warn_unclosed,
                         rsp_warn_extra_paren, rsp_warn_missing_quote);
   end

   // Result side: random stall bursts, one long hold-off on request.
   initial begin
      @(negedge reset);
      forever begin
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_req = 0;
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic send_char(byte unsigned c, bit last, bit gaps);
      if (gaps && !quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_char <= c;
      req_is_last   <= last;
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   task automatic send_text(text_type t);
      bit gaps;
      gaps = $urandom_range(0, 9) < 7;
      foreach (t[i]) send_char(t[i], i == t.size() - 1, gaps);
      exprs_sent++;
   endtask

   task automatic send_str(string s);
      text_type t;
      foreach (s[i]) t.push_back(s[i]);
      send_text(t);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      // An ignored tail may still be in flight after the last result.
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_address(logic [31:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.cur_addr = v;
   endtask

   function automatic string pick_operand(int lvl);
      string s, pre;
      byte unsigned ch;
      pre = "";
      case ($urandom_range(0, 9))
         0: pre = "~";
         1: pre = "-";
         default: ;
      endcase
      case ($urandom_range(0, 10))
         0: s = $sformatf("%0d", $urandom_range(0, 99));
         1: s = $sformatf("%0d", $urandom);
         2: s = $sformatf("$%0h", $urandom);
         3: s = "$";
         4: s = $sformatf("%%%0b", $urandom_range(0, 1023));
         5: s = $sformatf("0%0hh", $urandom);
         6: s = $sformatf("%0bb", $urandom_range(0, 255));
         7: s = $sformatf("%0dd", $urandom_range(0, 9999));
         8: begin
            ch = $urandom_range(32, 126);
            s = (ch == "\\") ? "'\\\\'" : $sformatf("'%c'", ch);
         end
         9: begin
            case ($urandom_range(0, 5))
               0: s = "'\\n'";
               1: s = "'\\r'";
               2: s = "'\\t'";
               3: s = "'\\0'";
               4: s = "'\\''";
               default: s = "'\\q'";
            endcase
         end
         default: s = (lvl < 4) ? {"(", pick_expr(lvl + 1), ")"} : "7";
      endcase
      return {pre, s};
   endfunction

   function automatic string pick_expr(int lvl);
      string ops[18] = '{"+", "-", "*", "/", "%", "^", "&", "|", "<<", ">>", "&&", "||",
                         "<", ">", "<=", ">=", "==", "!="};
      string s;
      s = pick_operand(lvl);
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 3) == 0) s = {s, " "};
         s = {s, ops[$urandom_range(0, 17)]};
         if ($urandom_range(0, 3) == 0) s = {s, "\t"};
         s = {s, pick_operand(lvl)};
      end
      return s;
   endfunction

   task automatic send_random();
      text_type t;
      string s;
      byte unsigned terms[5] = '{8'h00, 8'h0a, 8'h0d, ";", "\\"};
      int kind;
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
         // Noise: any byte values at all.
         repeat ($urandom_range(1, 6)) t.push_back($urandom_range(0, 255));
      end else begin
         s = pick_expr(0);
         if ($urandom_range(0, 9) == 0) s = {"(", s};
         if ($urandom_range(0, 19) == 0) s = {s, ")"};
         foreach (s[i]) t.push_back(s[i]);
         if (kind < 6) t[$urandom_range(0, t.size() - 1)] = $urandom_range(0, 255);
         if ($urandom_range(0, 9) == 0) begin
            t.push_back(terms[$urandom_range(0, 4)]);
            repeat ($urandom_range(0, 4)) t.push_back($urandom_range(0, 255));
         end
      end
      send_text(t);
   endtask

   initial begin
      text_type t;
      string directed[$];
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_text_char = '0;
      req_is_last = 1'b0;
      rsp_stall = 1'b0;
      cycles = 0;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_address(32'h0000_0000);
      directed = '{"0", "$", "$FFFFFFFF", "%1010", "4294967295", "0FFh", "101b", "99d",
                   "'A'", "'\\n'", "'\\#'", "'x", "'", "7/0", "7%0", "~0", "- 5", "--5",
                   "abc", "1!2", "1<=2>=1", "1)", "1;@@", ";", "1+", "-", "1<",
                   "$80000000/-1", "$80000000%-1", "1<<40", "-8>>99", "-7/2", "-7%2",
                   "1+2-3*4/5%6^7&8|9<<1>>1&&1||0<2>1<=3>=0==1!=0",
                   "(((((((((((((((((((1", "((((((((((((((((((((1"};
      foreach (directed[i]) send_str(directed[i]);
      t = '{8'h00};
      send_text(t);
      t = '{"1", "+", 8'h00};
      send_text(t);
      drain();

      write_address(32'hFFFF_FFFF);
      send_str("$");
      send_str("-$+1");
      while (chars_sent < 500) send_random();
      drain();

      write_address(32'h8000_0000);
      send_str("$");
      long_hold_req = 1;
      while (chars_sent < 900) send_random();
      drain();

      write_address($urandom);
      while (chars_sent < RANDOM_CHARS - QUIET_CHARS) send_random();
      drain();

      write_address(32'h0000_0001);
      quiet = 1;
      while (chars_sent < RANDOM_CHARS) send_random();
      drain();

      if (sb.pending() != 0) begin
         $error("%0d results never arrived", sb.pending());
         sb.errors++;
      end
      $display("Sent %0d characters in %0d expressions over %0d cycles.",
               chars_sent, exprs_sent, cycles);
      $display("Checked %0d results, %0d of them with an error status.",
               sb.checked, sb.bad_status);
      if (sb.errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
